### design/tspm_pkg.sv
// Package for the transform stack point mapper: command and result beat types,
// operation and status codes, sizing constants, arctangent table and saturation.
// Depends on nothing; tspm_mul, tspm_cordic and the top level import it.
`timescale 1ns / 1ps

package tspm_pkg;

	localparam int STACK_DEPTH  = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int COUNT_W = $clog2(STACK_DEPTH + 1);
	localparam int STEP_W  = $clog2(CORDIC_STEPS + 1);

	localparam logic signed [31:0] Q_ONE = 32'sd65536;
	localparam logic signed [33:0] DEG_FULL    = 34'sd23592960;
	localparam logic signed [33:0] DEG_HALF    = 34'sd11796480;
	localparam logic signed [33:0] DEG_QUARTER = 34'sd5898240;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef enum logic [2:0] {
		OP_PUSH  = 3'd0,
		OP_POP   = 3'd1,
		OP_MAP   = 3'd2,
		OP_RESET = 3'd3,
		OP_QUERY = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_SAT   = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_angle;
		logic signed [31:0] in_scale_x;
		logic signed [31:0] in_scale_y;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_angle;
		logic signed [31:0] out_scale_x;
		logic signed [31:0] out_scale_y;
		logic [4:0]         depth;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] angle;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
	} xform_t;

	localparam int XFORM_W = $bits(xform_t);

	// Arctangent of 2^-i in Q16.16 degrees.
	function automatic logic signed [33:0] atan_deg(input logic [4:0] i);
		logic signed [33:0] r;
		case (i)
			5'd0:  r = 34'sd2949120;
			5'd1:  r = 34'sd1740967;
			5'd2:  r = 34'sd919879;
			5'd3:  r = 34'sd466945;
			5'd4:  r = 34'sd234379;
			5'd5:  r = 34'sd117304;
			5'd6:  r = 34'sd58666;
			5'd7:  r = 34'sd29335;
			5'd8:  r = 34'sd14668;
			5'd9:  r = 34'sd7334;
			5'd10: r = 34'sd3667;
			5'd11: r = 34'sd1833;
			5'd12: r = 34'sd917;
			5'd13: r = 34'sd458;
			5'd14: r = 34'sd229;
			5'd15: r = 34'sd115;
			5'd16: r = 34'sd57;
			5'd17: r = 34'sd29;
			5'd18: r = 34'sd14;
			5'd19: r = 34'sd7;
			5'd20: r = 34'sd4;
			5'd21: r = 34'sd2;
			5'd22: r = 34'sd1;
			default: r = 34'sd0;
		endcase
		return r;
	endfunction

	// Saturates to 32 bits; the top bit of the result flags saturation.
	function automatic logic [32:0] sat32(input logic signed [69:0] v);
		logic [32:0] r;
		if (v > 70'sd2147483647)
			r = {1'b1, 32'h7fffffff};
		else if (v < -70'sd2147483648)
			r = {1'b1, 32'h80000000};
		else
			r = {1'b0, v[31:0]};
		return r;
	endfunction

	function automatic logic signed [69:0] ext32(input logic signed [31:0] v);
		return $signed({{38{v[31]}}, v});
	endfunction

endpackage

### design/tspm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the save stack of the transform stack point mapper.
`timescale 1ns / 1ps

module tspm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/tspm_mul.sv
// Shared signed 34 by 34 bit multiplier with a registered product.
// Depends on tspm_pkg only by convention of the block.
`timescale 1ns / 1ps

module tspm_mul import tspm_pkg::*; (
	input  logic               clk,
	input  logic signed [33:0] a,
	input  logic signed [33:0] b,
	output logic signed [67:0] p
);

	logic signed [67:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

### design/tspm_cordic.sv
// Sine and cosine of a Q16.16 degree angle: modulo-360 reduction by shift and
// subtract, quadrant fold, then one CORDIC step a cycle. Uses tspm_pkg.
`timescale 1ns / 1ps

module tspm_cordic import tspm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] angle,
	output logic               done,
	output logic signed [33:0] cos_v,
	output logic signed [33:0] sin_v
);

	typedef enum logic [1:0] {
		C_IDLE,
		C_RED,
		C_FIX,
		C_ROT
	} cstate_t;

	cstate_t            state_q;
	logic [2:0]         k_q;
	logic [STEP_W-1:0]  i_q;
	logic [33:0]        m_q;
	logic               sgn_q;
	logic               neg_q;
	logic signed [33:0] x_q, y_q, r_q;
	logic               done_q;

	logic [33:0]        mod_k;
	logic signed [33:0] r_fix;
	logic               neg_fix;
	logic [4:0]         i5;

	assign mod_k = 34'(DEG_FULL) << k_q;
	assign i5    = 5'(i_q);

	always_comb begin
		r_fix   = sgn_q ? -$signed(m_q) : $signed(m_q);
		neg_fix = 1'b0;
		if (r_fix < 0)
			r_fix = r_fix + DEG_FULL;
		if (r_fix > DEG_HALF)
			r_fix = r_fix - DEG_FULL;
		if (r_fix > DEG_QUARTER) begin
			r_fix   = r_fix - DEG_HALF;
			neg_fix = 1'b1;
		end else if (r_fix < -DEG_QUARTER) begin
			r_fix   = r_fix + DEG_HALF;
			neg_fix = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
			k_q     <= '0;
			i_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (start) begin
						sgn_q   <= angle[31];
						m_q     <= angle[31] ? 34'(-ext32(angle)) : 34'(ext32(angle));
						k_q     <= 3'd7;
						state_q <= C_RED;
					end
				end
				C_RED: begin
					if (m_q >= mod_k)
						m_q <= m_q - mod_k;
					if (k_q == 3'd0)
						state_q <= C_FIX;
					k_q <= k_q - 3'd1;
				end
				C_FIX: begin
					r_q     <= r_fix;
					neg_q   <= neg_fix;
					x_q     <= CORDIC_GAIN;
					y_q     <= '0;
					i_q     <= '0;
					state_q <= C_ROT;
				end
				C_ROT: begin
					if (r_q >= 0) begin
						x_q <= x_q - (y_q >>> i_q);
						y_q <= y_q + (x_q >>> i_q);
						r_q <= r_q - atan_deg(i5);
					end else begin
						x_q <= x_q + (y_q >>> i_q);
						y_q <= y_q - (x_q >>> i_q);
						r_q <= r_q + atan_deg(i5);
					end
					i_q <= i_q + 1'b1;
					if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign cos_v = neg_q ? -x_q : x_q;
	assign sin_v = neg_q ? -y_q : y_q;

endmodule

### design/transform_stack_point_mapper.sv
// Top level of the 2D transform stack point mapper: command sequencer, current
// transform registers and datapath. Uses tspm_pkg, tspm_ram, tspm_mul, tspm_cordic.
`timescale 1ns / 1ps

// Channel   Handshake              Beat
// command   start & !busy          request (cmd_t)
// result    done, one cycle        result (rsp_t), receiver cannot stall
//
// One command is in flight at a time; busy stays high from acceptance until
// the cycle in which done pulses, and a new command may be taken that cycle.
// Query, reset, an unused code and a rejected push or pop go straight to the
// result; a good pop reads the stack first. Map point scales, rotates when
// the angle is nonzero and adds the position; push rotates and scales, adds
// to position and angle, then scales the scale. Rotation adds the angle reduction
// (8 steps), the CORDIC_STEPS CORDIC iterations, handoff and the four shared multiplies.
// Reset restores the identity transform and an empty stack. Stack entries are
// never cleared: only entries that a push wrote are ever read back.

module transform_stack_point_mapper import tspm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t request,
	output logic done,
	output rsp_t result
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_WCOR,
		S_ROT0,
		S_ROT1,
		S_ROT2,
		S_ROT3,
		S_ROT4,
		S_QS0,
		S_QS1,
		S_QS2,
		S_ADDP,
		S_SC0,
		S_SC1,
		S_SC2,
		S_POPR,
		S_POPW,
		S_DONE
	} state_t;

	state_t             state_q;
	cmd_t               req_q;
	logic signed [31:0] pos_x_q, pos_y_q, ang_q, scx_q, scy_q;
	logic [COUNT_W-1:0] count_q;
	logic signed [31:0] vx_q, vy_q;
	logic signed [69:0] t_q;
	logic               sat_q;
	logic [1:0]         status_q;
	logic               cor_start_q;
	logic               done_q;
	rsp_t               result_q;

	logic               accept;
	logic               full;
	logic               ram_we;
	xform_t             ram_wdata;
	xform_t             ram_rdata;
	logic [XFORM_W-1:0] ram_rbits;
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] prod;
	logic               cor_done;
	logic signed [33:0] cos_v, sin_v;
	logic signed [69:0] prod70;
	logic [32:0]        q16, rot_diff, rot_sum;
	logic [32:0]        add_x, add_y, add_a;
	logic               rot_needed;

	assign accept     = start && (state_q == S_IDLE);
	assign busy       = (state_q != S_IDLE);
	assign full       = (count_q == COUNT_W'(STACK_DEPTH));
	assign rot_needed = (ang_q != 32'sd0);

	// The save stack is written on the accepting edge of a push with room.
	assign ram_we    = accept && (op_t'(request.operation) == OP_PUSH) && !full;
	assign ram_wdata = '{pos_x: pos_x_q, pos_y: pos_y_q, angle: ang_q,
	                     scale_x: scx_q, scale_y: scy_q};
	assign ram_rdata = xform_t'(ram_rbits);

	tspm_ram #(
		.WIDTH(XFORM_W),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(ram_wdata),
		.raddr(count_q[ADDR_W-1:0]),
		.rdata(ram_rbits)
	);

	// Operand selection for the shared multiplier: the product is registered
	// and is consumed by the following state.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_ROT0: begin mul_a = 34'(vx_q);  mul_b = cos_v; end
			S_ROT1: begin mul_a = 34'(vy_q);  mul_b = sin_v; end
			S_ROT2: begin mul_a = 34'(vx_q);  mul_b = sin_v; end
			S_ROT3: begin mul_a = 34'(vy_q);  mul_b = cos_v; end
			S_QS0:  begin mul_a = 34'(vx_q);  mul_b = 34'(scx_q); end
			S_QS1:  begin mul_a = 34'(vy_q);  mul_b = 34'(scy_q); end
			S_SC0:  begin mul_a = 34'(scx_q); mul_b = 34'(req_q.in_scale_x); end
			S_SC1:  begin mul_a = 34'(scy_q); mul_b = 34'(req_q.in_scale_y); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	tspm_mul u_mul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.p  (prod)
	);

	tspm_cordic u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cor_start_q),
		.angle (ang_q),
		.done  (cor_done),
		.cos_v (cos_v),
		.sin_v (sin_v)
	);

	// Rounding and saturation of the product paths and the position and angle adds.
	assign prod70   = $signed({{2{prod[67]}}, prod});
	assign q16      = sat32((prod70 + 70'sd32768) >>> 16);
	assign rot_diff = sat32((t_q - prod70 + 70'sd536870912) >>> 30);
	assign rot_sum  = sat32((t_q + prod70 + 70'sd536870912) >>> 30);
	assign add_x    = sat32(ext32(pos_x_q) + ext32(vx_q));
	assign add_y    = sat32(ext32(pos_y_q) + ext32(vy_q));
	assign add_a    = sat32(ext32(ang_q) + ext32(req_q.in_angle));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			ang_q       <= '0;
			scx_q       <= Q_ONE;
			scy_q       <= Q_ONE;
			count_q     <= '0;
			cor_start_q <= 1'b0;
			done_q      <= 1'b0;
			sat_q       <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			cor_start_q <= 1'b0;
			done_q      <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q    <= request;
						vx_q     <= request.in_x;
						vy_q     <= request.in_y;
						sat_q    <= 1'b0;
						// A full push and an empty pop are the only rejected beats.
						status_q <= (op_t'(request.operation) == OP_PUSH && full) ? ST_FULL :
						            (op_t'(request.operation) == OP_POP && count_q == '0) ?
						            ST_EMPTY : ST_OK;
						case (op_t'(request.operation))
							OP_PUSH: begin
								if (full) begin
									state_q  <= S_DONE;
								end else begin
									count_q <= count_q + 1'b1;
									if (rot_needed) begin
										cor_start_q <= 1'b1;
										state_q     <= S_WCOR;
									end else begin
										state_q <= S_QS0;
									end
								end
							end
							OP_POP: begin
								if (count_q == '0) begin
									state_q  <= S_DONE;
								end else begin
									count_q <= count_q - 1'b1;
									state_q <= S_POPR;
								end
							end
							OP_MAP: state_q <= S_QS0;
							OP_RESET: begin
								pos_x_q <= '0;
								pos_y_q <= '0;
								ang_q   <= '0;
								scx_q   <= Q_ONE;
								scy_q   <= Q_ONE;
								count_q <= '0;
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_WCOR: begin
					if (cor_done)
						state_q <= S_ROT0;
				end
				S_ROT0: state_q <= S_ROT1;
				S_ROT1: begin
					t_q     <= prod70;
					state_q <= S_ROT2;
				end
				S_ROT2: begin
					vx_q    <= rot_diff[31:0];
					sat_q   <= sat_q | rot_diff[32];
					state_q <= S_ROT3;
				end
				S_ROT3: begin
					t_q     <= prod70;
					state_q <= S_ROT4;
				end
				S_ROT4: begin
					vy_q    <= rot_sum[31:0];
					sat_q   <= sat_q | rot_sum[32];
					state_q <= (op_t'(req_q.operation) == OP_PUSH) ? S_QS0 : S_ADDP;
				end
				S_QS0: state_q <= S_QS1;
				S_QS1: begin
					vx_q    <= q16[31:0];
					sat_q   <= sat_q | q16[32];
					state_q <= S_QS2;
				end
				S_QS2: begin
					vy_q  <= q16[31:0];
					sat_q <= sat_q | q16[32];
					// Map point rotates after scaling; push has rotated already.
					if (op_t'(req_q.operation) == OP_MAP && rot_needed) begin
						cor_start_q <= 1'b1;
						state_q     <= S_WCOR;
					end else begin
						state_q <= S_ADDP;
					end
				end
				S_ADDP: begin
					if (op_t'(req_q.operation) == OP_PUSH) begin
						pos_x_q <= add_x[31:0];
						pos_y_q <= add_y[31:0];
						ang_q   <= add_a[31:0];
						sat_q   <= sat_q | add_x[32] | add_y[32] | add_a[32];
						state_q <= S_SC0;
					end else begin
						vx_q    <= add_x[31:0];
						vy_q    <= add_y[31:0];
						sat_q   <= sat_q | add_x[32] | add_y[32];
						state_q <= S_DONE;
					end
				end
				S_SC0: state_q <= S_SC1;
				S_SC1: begin
					scx_q   <= q16[31:0];
					sat_q   <= sat_q | q16[32];
					state_q <= S_SC2;
				end
				S_SC2: begin
					scy_q   <= q16[31:0];
					sat_q   <= sat_q | q16[32];
					state_q <= S_DONE;
				end
				S_POPR: state_q <= S_POPW;
				S_POPW: begin
					pos_x_q <= ram_rdata.pos_x;
					pos_y_q <= ram_rdata.pos_y;
					ang_q   <= ram_rdata.angle;
					scx_q   <= ram_rdata.scale_x;
					scy_q   <= ram_rdata.scale_y;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (op_t'(req_q.operation) == OP_MAP) begin
						result_q.out_x <= vx_q;
						result_q.out_y <= vy_q;
					end else begin
						result_q.out_x <= pos_x_q;
						result_q.out_y <= pos_y_q;
					end
					result_q.out_angle   <= ang_q;
					result_q.out_scale_x <= scx_q;
					result_q.out_scale_y <= scy_q;
					result_q.depth       <= 5'(count_q);
					result_q.status      <= sat_q ? ST_SAT : status_q;
					done_q               <= 1'b1;
					state_q              <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
